FILE: hdl/timed_edge_sequence_detector_defines.svh
// ----------------------------------------------------------------------------
// Timed edge sequence detector assertion macros
// Concurrent check helpers, compiled out when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef TIMED_EDGE_SEQUENCE_DETECTOR_DEFINES_SVH
`define TIMED_EDGE_SEQUENCE_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication
`define TESD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication
`define TESD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define TESD_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define TESD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

FILE: hdl/tesd_pkg.sv
// ----------------------------------------------------------------------------
// Timed edge sequence detector package
// Shared widths, constants and types of the detector and its channels.
// ----------------------------------------------------------------------------
package tesd_pkg;

  // Default sizing
  localparam int NUM_SEQUENCES = 4;
  localparam int MAX_STEPS     = 8;
  localparam int NUM_SIGNALS   = 16;

  // Field widths
  localparam int LEVEL_W    = 16;
  localparam int TIME_W     = 32;
  localparam int MASK_W     = 4;
  localparam int PAT_W      = 44;
  localparam int WIN_W      = 16;
  localparam int PROG_W     = 4;
  localparam int SIG_W      = 4;
  localparam int STEP_W     = 5;
  localparam int STEP_BASE  = 4;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 44;

  // Window limits
  localparam logic [WIN_W-1:0] MIN_WINDOW_MS = WIN_W'(1000);
  localparam logic [WIN_W-1:0] WIN_RESET     = WIN_W'(1000);

  // Register map: patterns first, then windows
  localparam int CFG_PAT_BASE = 0;
  localparam int CFG_WIN_BASE = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_OUT
  } tesd_state_e;

  typedef struct packed {
    logic in_ready;
    logic rd_fire;
    logic out_load;
  } tesd_ctrl_t;

endpackage

FILE: hdl/tesd_if.sv
// ----------------------------------------------------------------------------
// Timed edge sequence detector channels
// Tick input, fired output and configuration write channels.
// ----------------------------------------------------------------------------
interface tesd_tick_if;
  logic                        valid;
  logic                        ready;
  logic [tesd_pkg::LEVEL_W-1:0] current_levels;
  logic [tesd_pkg::LEVEL_W-1:0] previous_levels;
  logic [tesd_pkg::TIME_W-1:0]  now_ms;

  modport source (output valid, current_levels, previous_levels, now_ms, input ready);
  modport sink   (input valid, current_levels, previous_levels, now_ms, output ready);
endinterface

interface tesd_fire_if;
  logic                       valid;
  logic                       ready;
  logic [tesd_pkg::MASK_W-1:0] fired_mask;

  modport source (output valid, fired_mask, input ready);
  modport sink   (input valid, fired_mask, output ready);
endinterface

interface tesd_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [tesd_pkg::CFG_IDX_W-1:0]  index;
  logic [tesd_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: hdl/timed_edge_sequence_detector.sv
// ----------------------------------------------------------------------------
// Timed edge sequence detector
// Per-sequence progress and window start live in two small synchronous
// memories; each tick reads, updates and writes back every sequence in turn.
// ----------------------------------------------------------------------------
// Result: registered in the output register once the walk through the run, wait
//   and output states ends; a new tick is taken only back in the idle state,
//   after one memory read per sequence through the shared update stage.
// Reset: progress and window start read as zero (per-entry valid flags),
//   patterns clear to zero, windows return to 1000 ms; no clearing pass.
`include "timed_edge_sequence_detector_defines.svh"

module timed_edge_sequence_detector #(
  parameter int NumSequences = tesd_pkg::NUM_SEQUENCES,
  parameter int MaxSteps     = tesd_pkg::MAX_STEPS,
  parameter int NumSignals   = tesd_pkg::NUM_SIGNALS
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  tesd_tick_if.sink     tick_i,
  tesd_cfg_if.sink      cfg_i,
  tesd_fire_if.source   fire_o
);

  localparam int IdxW = (NumSequences > 1) ? $clog2(NumSequences) : 1;
  localparam int PW   = tesd_pkg::PROG_W;
  localparam int TW   = tesd_pkg::TIME_W;
  localparam int WW   = tesd_pkg::WIN_W;
  localparam int MW   = tesd_pkg::MASK_W;

  // Configuration registers
  logic [tesd_pkg::PAT_W-1:0] pattern_q [NumSequences];
  logic [WW-1:0]              window_q  [NumSequences];

  // State memories and their valid flags
  logic [PW-1:0] prog_mem [NumSequences];
  logic [TW-1:0] ws_mem   [NumSequences];
  logic [NumSequences-1:0] prog_vld_q, ws_vld_q;

  // Control
  tesd_pkg::tesd_state_e state_q, state_d;
  tesd_pkg::tesd_ctrl_t  ctrl;
  logic [IdxW-1:0]       seq_q;
  logic                  tick_acc, cfg_wr;

  // Latched tick
  logic [tesd_pkg::LEVEL_W-1:0] cur_q, prev_q;
  logic [TW-1:0]                now_q;

  // Update stage
  logic            s1_vld_q;
  logic [IdxW-1:0] s1_idx_q;
  logic [PW-1:0]   prog_rd_q;
  logic [TW-1:0]   ws_rd_q;
  logic            prog_rd_v_q, ws_rd_v_q;
  logic [MW-1:0]   fired_q, fired_d;

  // Output register
  logic          out_vld_q;
  logic [MW-1:0] out_mask_q;

  assign tick_acc    = tick_i.valid && tick_i.ready;
  assign cfg_wr      = cfg_i.valid && cfg_i.ready;
  // Take register writes only between sequence walks
  assign cfg_i.ready = (state_q == tesd_pkg::ST_IDLE);
  assign tick_i.ready = ctrl.in_ready;
  assign fire_o.valid      = out_vld_q;
  assign fire_o.fired_mask = out_mask_q;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      tesd_pkg::ST_IDLE: begin
        if (tick_acc) state_d = tesd_pkg::ST_RUN;
      end
      tesd_pkg::ST_RUN: begin
        if (seq_q == IdxW'(NumSequences - 1)) state_d = tesd_pkg::ST_WAIT;
      end
      tesd_pkg::ST_WAIT: begin
        state_d = tesd_pkg::ST_OUT;
      end
      tesd_pkg::ST_OUT: begin
        if (!out_vld_q || fire_o.ready) state_d = tesd_pkg::ST_IDLE;
      end
      default: state_d = tesd_pkg::ST_IDLE;
    endcase
  end

  // Control outputs
  always_comb begin
    ctrl = '0;
    case (state_q)
      tesd_pkg::ST_IDLE: ctrl.in_ready = 1'b1;
      tesd_pkg::ST_RUN:  ctrl.rd_fire  = 1'b1;
      tesd_pkg::ST_OUT:  ctrl.out_load = !out_vld_q || fire_o.ready;
      default:           ctrl = '0;
    endcase
  end

  // Advance state and sequence counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= tesd_pkg::ST_IDLE;
      seq_q   <= '0;
    end else begin
      state_q <= state_d;
      if (tick_acc) begin
        seq_q <= '0;
      end else if (ctrl.rd_fire) begin
        seq_q <= seq_q + IdxW'(1);
      end
    end
  end

  // Hold the tick fields
  always_ff @(posedge clk_i) begin
    if (tick_acc) begin
      cur_q  <= tick_i.current_levels;
      prev_q <= tick_i.previous_levels;
      now_q  <= tick_i.now_ms;
    end
  end

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumSequences; i++) begin
        pattern_q[i] <= '0;
        window_q[i]  <= tesd_pkg::WIN_RESET;
      end
    end else if (cfg_wr) begin
      for (int i = 0; i < NumSequences; i++) begin
        if (cfg_i.index == tesd_pkg::CFG_IDX_W'(tesd_pkg::CFG_PAT_BASE + i)) begin
          pattern_q[i] <= cfg_i.data;
        end
        if (cfg_i.index == tesd_pkg::CFG_IDX_W'(tesd_pkg::CFG_WIN_BASE + i)) begin
          window_q[i] <= cfg_i.data[WW-1:0];
        end
      end
    end
  end

  // Memory read
  always_ff @(posedge clk_i) begin
    if (ctrl.rd_fire) begin
      prog_rd_q   <= prog_mem[seq_q];
      ws_rd_q     <= ws_mem[seq_q];
      prog_rd_v_q <= prog_vld_q[seq_q];
      ws_rd_v_q   <= ws_vld_q[seq_q];
      s1_idx_q    <= seq_q;
    end
  end

  // Update stage: window check, step walk, completion
  logic [tesd_pkg::PAT_W-1:0] pat;
  logic [WW-1:0]              win_eff;
  logic [PW-1:0]              count, prog_cur, prog_walk, prog_new;
  logic [TW-1:0]              ws_cur, elapsed, ws_new;
  logic                       expire, fire;
  logic [MaxSteps-1:0]        match;
  logic [tesd_pkg::STEP_W-1:0] slot;
  logic [tesd_pkg::SIG_W-1:0]  sig;

  always_comb begin
    pat      = pattern_q[s1_idx_q];
    win_eff  = (window_q[s1_idx_q] < tesd_pkg::MIN_WINDOW_MS) ?
               tesd_pkg::MIN_WINDOW_MS : window_q[s1_idx_q];
    count    = (pat[PW-1:0] > PW'(MaxSteps)) ? PW'(MaxSteps) : pat[PW-1:0];
    prog_cur = prog_rd_v_q ? prog_rd_q : '0;
    ws_cur   = ws_rd_v_q ? ws_rd_q : '0;
    elapsed  = now_q - ws_cur;
    expire   = elapsed >= TW'(win_eff);

    // Edge present for each step
    slot  = '0;
    sig   = '0;
    match = '0;
    for (int k = 0; k < MaxSteps; k++) begin
      slot = pat[tesd_pkg::STEP_BASE + tesd_pkg::STEP_W * k +: tesd_pkg::STEP_W];
      sig  = slot[tesd_pkg::SIG_W-1:0];
      match[k] = ({1'b0, sig} < (tesd_pkg::SIG_W + 1)'(NumSignals)) &&
                 (cur_q[sig] != prev_q[sig]) &&
                 (cur_q[sig] == !slot[tesd_pkg::STEP_W-1]);
    end

    // Walk consecutive steps from the current progress
    prog_walk = expire ? '0 : prog_cur;
    for (int k = 0; k < MaxSteps; k++) begin
      if (prog_walk == PW'(k) && prog_walk < count && match[k]) begin
        prog_walk = prog_walk + PW'(1);
      end
    end

    fire     = (count != '0) && (prog_walk == count);
    prog_new = fire ? '0 : prog_walk;
    ws_new   = (fire || expire) ? now_q : ws_cur;
    fired_d  = fired_q | (MW'(fire) << s1_idx_q);
  end

  // Memory write-back
  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      prog_mem[s1_idx_q] <= prog_new;
      ws_mem[s1_idx_q]   <= ws_new;
    end
  end

  // Valid flags, stage valid and fired accumulation
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prog_vld_q <= '0;
      ws_vld_q   <= '0;
      s1_vld_q   <= 1'b0;
      fired_q    <= '0;
    end else begin
      s1_vld_q <= ctrl.rd_fire;
      if (tick_acc) begin
        fired_q <= '0;
      end else if (s1_vld_q) begin
        fired_q <= fired_d;
      end
      if (s1_vld_q) begin
        prog_vld_q[s1_idx_q] <= 1'b1;
        ws_vld_q[s1_idx_q]   <= 1'b1;
      end
      // Drop progress of a rewritten pattern
      if (cfg_wr) begin
        for (int i = 0; i < NumSequences; i++) begin
          if (cfg_i.index == tesd_pkg::CFG_IDX_W'(tesd_pkg::CFG_PAT_BASE + i)) begin
            prog_vld_q[i] <= 1'b0;
          end
        end
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (ctrl.out_load) begin
      out_vld_q <= 1'b1;
    end else if (fire_o.ready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.out_load) begin
      out_mask_q <= fired_q;
    end
  end

  // Checks
  `TESD_ASSERT_NEXT(a_tick_starts_run, clk_i, rst_ni, tick_acc,
                    (state_q == tesd_pkg::ST_RUN) && (seq_q == '0),
                    "tick transaction did not start a sequence walk")
  `TESD_ASSERT_IMPL(a_update_in_item, clk_i, rst_ni, s1_vld_q,
                    (state_q == tesd_pkg::ST_RUN) || (state_q == tesd_pkg::ST_WAIT),
                    "update stage active outside an item")
  `TESD_ASSERT_IMPL(a_progress_bound, clk_i, rst_ni, s1_vld_q,
                    prog_new < PW'(MaxSteps),
                    "written progress out of range")
  `TESD_ASSERT_NEXT(a_load_shows_result, clk_i, rst_ni, ctrl.out_load,
                    out_vld_q && (out_mask_q == $past(fired_q)),
                    "result not presented after load")

endmodule

FILE: bench/tesd_checker.sv
// ----------------------------------------------------------------------------
// Timed edge sequence detector checker
// Watches the tick, configuration and fired channels, keeps its own copy of
// the per-sequence progress and window state, predicts the fired mask of
// every accepted tick and compares it with the result transactions in order.
// ----------------------------------------------------------------------------
module tesd_checker
  import tesd_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  tick_valid_i,
  input  logic                  tick_ready_i,
  input  logic [LEVEL_W-1:0]    cur_levels_i,
  input  logic [LEVEL_W-1:0]    prev_levels_i,
  input  logic [TIME_W-1:0]     now_ms_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  fire_valid_i,
  input  logic                  fire_ready_i,
  input  logic [MASK_W-1:0]     fired_mask_i,
  output int                    mismatches_o,
  output int                    pending_o,
  output int                    checked_o,
  output int                    fired_o
);

  localparam int REPORT_LIMIT = 10;

  // Shadow of the detector registers and per-sequence state
  logic [PAT_W-1:0]  pattern_r   [NUM_SEQUENCES];
  logic [WIN_W-1:0]  window_r    [NUM_SEQUENCES];
  logic [PROG_W-1:0] progress_r  [NUM_SEQUENCES];
  logic [TIME_W-1:0] win_start_r [NUM_SEQUENCES];

  logic [MASK_W-1:0] fired_q [$];

  // Apply one register write; a pattern write restarts that sequence's walk
  function automatic void apply_write(input logic [CFG_IDX_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
    int slot;
    slot = int'(idx);
    if (slot >= CFG_PAT_BASE && slot < CFG_PAT_BASE + NUM_SEQUENCES) begin
      pattern_r[slot - CFG_PAT_BASE]  = data[PAT_W-1:0];
      progress_r[slot - CFG_PAT_BASE] = '0;
    end else if (slot >= CFG_WIN_BASE && slot < CFG_WIN_BASE + NUM_SEQUENCES) begin
      window_r[slot - CFG_WIN_BASE] = data[WIN_W-1:0];
    end
  endfunction

  // Advance every sequence over one tick and return the mask of completions
  function automatic logic [MASK_W-1:0] next_fired_mask(input logic [LEVEL_W-1:0] cur,
                                                        input logic [LEVEL_W-1:0] prev,
                                                        input logic [TIME_W-1:0] now);
    logic [MASK_W-1:0] mask;
    logic [PROG_W-1:0] steps;
    logic [WIN_W-1:0]  span;
    logic [TIME_W-1:0] elapsed;
    logic [STEP_W-1:0] slot;
    logic [SIG_W-1:0]  sig;
    logic              matched;
    mask = '0;
    for (int s = 0; s < NUM_SEQUENCES; s++) begin
      steps = pattern_r[s][PROG_W-1:0];
      if (steps > MAX_STEPS) steps = PROG_W'(MAX_STEPS);
      span = (window_r[s] < MIN_WINDOW_MS) ? MIN_WINDOW_MS : window_r[s];

      // restart the window once it has run out
      elapsed = now - win_start_r[s];
      if (elapsed >= TIME_W'(span)) begin
        progress_r[s]  = '0;
        win_start_r[s] = now;
      end

      // walk as many steps as this tick's edges allow
      matched = 1'b1;
      while (matched && progress_r[s] < steps) begin
        slot = pattern_r[s][STEP_BASE + STEP_W*progress_r[s] +: STEP_W];
        sig  = slot[SIG_W-1:0];
        if (int'(sig) >= NUM_SIGNALS) matched = 1'b0;
        else if (slot[SIG_W]) matched = !cur[sig] && prev[sig];
        else matched = cur[sig] && !prev[sig];
        if (matched) progress_r[s] = progress_r[s] + 1'b1;
      end

      if (steps != 0 && progress_r[s] == steps) begin
        mask[s]        = 1'b1;
        progress_r[s]  = '0;
        win_start_r[s] = now;
      end
    end
    return mask;
  endfunction

  function automatic void note_mismatch(input string what,
                                        input logic [MASK_W-1:0] want,
                                        input logic [MASK_W-1:0] got);
    if (mismatches_o < REPORT_LIMIT)
      $display("[%0t] MISMATCH %s: expected fired_mask %b, got %b", $time, what, want, got);
    mismatches_o++;
  endfunction

  // Retire results first, then take configuration and tick transactions
  always @(posedge clk_i or negedge rst_ni) begin : scoreboard
    logic [MASK_W-1:0] want;
    if (!rst_ni) begin
      for (int s = 0; s < NUM_SEQUENCES; s++) begin
        pattern_r[s]   = '0;
        window_r[s]    = WIN_RESET;
        progress_r[s]  = '0;
        win_start_r[s] = '0;
      end
      fired_q.delete();
      mismatches_o = 0;
      pending_o    = 0;
      checked_o    = 0;
      fired_o      = 0;
    end else begin
      if (fire_valid_i && fire_ready_i) begin
        if (fired_q.size() == 0) begin
          note_mismatch("result with no tick outstanding", '0, fired_mask_i);
        end else begin
          want = fired_q.pop_front();
          checked_o++;
          if (fired_mask_i != '0) fired_o++;
          if (fired_mask_i !== want) note_mismatch("fired_mask", want, fired_mask_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) apply_write(cfg_index_i, cfg_data_i);
      if (tick_valid_i && tick_ready_i)
        fired_q.push_back(next_fired_mask(cur_levels_i, prev_levels_i, now_ms_i));
      pending_o = fired_q.size();
    end
  end

endmodule

FILE: bench/tb_top.sv
// ----------------------------------------------------------------------------
// Timed edge sequence detector testbench
// Drives directed ticks over the edge, window and register corner cases, then
// several configuration phases of mostly well-formed edge sequences with
// random timing, noise, window expiry, back-pressure and drained pauses.
// Checking is done by tesd_checker; this module makes stimulus and verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import tesd_pkg::*;

  localparam int PHASES       = 6;
  localparam int PHASE_TICKS  = 230;
  localparam int HOLD_CYCLES  = 80;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 4 * (NUM_SEQUENCES + 3);
  localparam int CFG_IDX_MAX  = (1 << CFG_IDX_W) - 1;
  localparam int CFG_FREE_LO  = CFG_WIN_BASE + NUM_SEQUENCES;
  localparam int MAX_GAP      = 6;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  tesd_tick_if tick_ch ();
  tesd_cfg_if  cfg_ch ();
  tesd_fire_if fire_ch ();

  int mismatches, pending, checked, fired;

  // Stimulus-side view of the patterns and where each sequence is expected to be
  logic [PAT_W-1:0]  pat_shadow [NUM_SEQUENCES];
  int                cursor     [NUM_SEQUENCES];
  logic [TIME_W-1:0] clock_ms;
  logic              calm;
  logic              tick_live;
  logic              cfg_live;
  int                rx_hold;
  int                ticks_sent;
  int                writes_done;

  timed_edge_sequence_detector u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .tick_i (tick_ch),
    .cfg_i  (cfg_ch),
    .fire_o (fire_ch)
  );

  tesd_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .tick_valid_i  (tick_ch.valid),
    .tick_ready_i  (tick_ch.ready),
    .cur_levels_i  (tick_ch.current_levels),
    .prev_levels_i (tick_ch.previous_levels),
    .now_ms_i      (tick_ch.now_ms),
    .cfg_valid_i   (cfg_ch.valid),
    .cfg_ready_i   (cfg_ch.ready),
    .cfg_index_i   (cfg_ch.index),
    .cfg_data_i    (cfg_ch.data),
    .fire_valid_i  (fire_ch.valid),
    .fire_ready_i  (fire_ch.ready),
    .fired_mask_i  (fire_ch.fired_mask),
    .mismatches_o  (mismatches),
    .pending_o     (pending),
    .checked_o     (checked),
    .fired_o       (fired)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic int draw_gap();
    return calm ? 0 : $urandom_range(0, MAX_GAP);
  endfunction

  function automatic int active_steps(input int s);
    int steps;
    steps = int'(pat_shadow[s][PROG_W-1:0]);
    return (steps > MAX_STEPS) ? MAX_STEPS : steps;
  endfunction

  // Offer one tick; valid stays high after acceptance unless the next one waits
  task automatic send_tick(input logic [LEVEL_W-1:0] cur, input logic [LEVEL_W-1:0] prev,
                           input logic [TIME_W-1:0] now);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      tick_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    tick_ch.valid           <= 1'b1;
    tick_ch.current_levels  <= cur;
    tick_ch.previous_levels <= prev;
    tick_ch.now_ms          <= now;
    do @(posedge clk_i); while (!tick_ch.ready);
    @(negedge clk_i);
    tick_live = 1'b1;
    ticks_sent++;
  endtask

  task automatic write_reg(input int idx, input logic [CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= CFG_IDX_W'(idx);
    cfg_ch.data  <= data;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_live = 1'b1;
    writes_done++;
    if (idx >= CFG_PAT_BASE && idx < CFG_PAT_BASE + NUM_SEQUENCES) begin
      pat_shadow[idx - CFG_PAT_BASE] = data[PAT_W-1:0];
      cursor[idx - CFG_PAT_BASE]     = 0;
    end
  endtask

  task automatic cfg_quiet();
    if (cfg_live) cfg_ch.valid <= 1'b0;
    cfg_live = 1'b0;
  endtask

  // Drop tick valid and hold until every outstanding result has come back
  task automatic wait_drained();
    if (tick_live) tick_ch.valid <= 1'b0;
    tick_live = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [PAT_W-1:0] random_pattern();
    logic [PAT_W-1:0] pat;
    int roll;
    pat  = PAT_W'({$urandom, $urandom});
    roll = $urandom_range(0, 9);
    if (roll == 0) pat[PROG_W-1:0] = '0;
    else if (roll == 1) pat[PROG_W-1:0] = PROG_W'($urandom_range(MAX_STEPS + 1, 15));
    else pat[PROG_W-1:0] = PROG_W'($urandom_range(1, MAX_STEPS));
    // crowd the steps onto a few signals so repeated edges show up
    if ($urandom_range(0, 2) == 0)
      for (int k = 0; k < MAX_STEPS; k++) pat[STEP_BASE + STEP_W*k + 2 +: 2] = '0;
    return pat;
  endfunction

  function automatic logic [CFG_DATA_W-1:0] random_window();
    logic [CFG_DATA_W-1:0] val;
    int roll;
    val  = CFG_DATA_W'({$urandom, $urandom});
    roll = $urandom_range(0, 9);
    if (roll == 0) val[WIN_W-1:0] = WIN_W'($urandom_range(0, MIN_WINDOW_MS - 1));
    else if (roll == 1) val[WIN_W-1:0] = '1;
    else val[WIN_W-1:0] = WIN_W'($urandom_range(MIN_WINDOW_MS, 2500));
    return val;
  endfunction

  // Build levels that carry the next expected edge of sequence s, sometimes more
  function automatic void build_step_tick(input int s, output logic [LEVEL_W-1:0] cur,
                                          output logic [LEVEL_W-1:0] prev);
    logic [LEVEL_W-1:0] pinned;
    logic [STEP_W-1:0]  slot;
    logic [SIG_W-1:0]   sig;
    logic               matched;
    logic               more;
    int                 steps;
    steps  = active_steps(s);
    prev   = LEVEL_W'($urandom);
    cur    = prev;
    if ($urandom_range(0, 3) == 0) cur = cur ^ LEVEL_W'($urandom & $urandom);
    pinned = '0;
    do begin
      slot = pat_shadow[s][STEP_BASE + STEP_W*cursor[s] +: STEP_W];
      sig  = slot[SIG_W-1:0];
      if (!pinned[sig]) begin
        prev[sig]   = slot[SIG_W];
        cur[sig]    = !slot[SIG_W];
        pinned[sig] = 1'b1;
      end
      matched = (cur[sig] != prev[sig]) && (prev[sig] == slot[SIG_W]);
      if (matched) cursor[s] = (cursor[s] + 1) % steps;
      more = matched && cursor[s] != 0 && $urandom_range(0, 1) == 1;
    end while (more);
  endfunction

  task automatic random_tick();
    int roll;
    int s;
    logic [LEVEL_W-1:0] cur;
    logic [LEVEL_W-1:0] prev;
    // advance time, now and then past the windows or to anywhere at all
    roll = $urandom_range(0, 99);
    if (roll < 88) begin
      clock_ms += TIME_W'($urandom_range(0, 60));
    end else begin
      if (roll < 95) clock_ms += TIME_W'($urandom_range(1000, 70000));
      else clock_ms = TIME_W'($urandom);
      foreach (cursor[k]) cursor[k] = 0;
    end
    roll = $urandom_range(0, 99);
    s    = $urandom_range(0, NUM_SEQUENCES - 1);
    if (roll < 70 && active_steps(s) != 0) begin
      build_step_tick(s, cur, prev);
    end else if (roll < 85 || roll < 70) begin
      cur  = LEVEL_W'($urandom);
      prev = LEVEL_W'($urandom);
    end else begin
      cur  = LEVEL_W'($urandom);
      prev = cur;
    end
    send_tick(cur, prev, clock_ms);
  endtask

  // Load all registers for one phase: maxima first, then zero windows with random patterns, then random
  task automatic configure_phase(input int ph);
    wait_drained();
    for (int s = 0; s < NUM_SEQUENCES; s++)
      write_reg(CFG_PAT_BASE + s, (ph == 0) ? '1 : CFG_DATA_W'(random_pattern()));
    for (int s = 0; s < NUM_SEQUENCES; s++)
      write_reg(CFG_WIN_BASE + s, (ph == 0) ? CFG_DATA_W'({WIN_W{1'b1}}) :
                                  (ph == 1) ? '0 : random_window());
    write_reg($urandom_range(CFG_FREE_LO, CFG_IDX_MAX), CFG_DATA_W'({$urandom, $urandom}));
    cfg_quiet();
    clock_ms = TIME_W'(0) - TIME_W'($urandom_range(0, 20000));
  endtask

  task automatic directed_ticks();
    // reset configuration: everything disabled, level and time extremes
    send_tick(16'h0000, 16'h0000, 32'h0000_0000);
    send_tick(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_tick(16'h0000, 16'hFFFF, 32'h0000_0000);
    wait_drained();
    // seq0: count above maximum, eight rising steps on signal 0 in one tick
    write_reg(CFG_PAT_BASE + 0, 44'h000_0000_000F);
    // seq1: falling on signal 15, then rising on signal 3
    write_reg(CFG_PAT_BASE + 1, 44'h000_0000_07F2);
    // seq2: eight falling steps on signal 15
    write_reg(CFG_PAT_BASE + 2, 44'hFFF_FFFF_FFF8);
    // seq3: rise on 1, fall on 2, fall on 1
    write_reg(CFG_PAT_BASE + 3, 44'h000_0004_6413);
    write_reg(CFG_WIN_BASE + 0, CFG_DATA_W'(MIN_WINDOW_MS - 1));
    write_reg(CFG_WIN_BASE + 1, '0);
    write_reg(CFG_WIN_BASE + 2, CFG_DATA_W'(MIN_WINDOW_MS));
    write_reg(CFG_WIN_BASE + 3, CFG_DATA_W'({WIN_W{1'b1}}));
    write_reg(CFG_FREE_LO, '1);
    write_reg(CFG_IDX_MAX, '1);
    cfg_quiet();
    send_tick(16'h0001, 16'h0000, 32'd100);
    send_tick(16'h0000, 16'h8000, 32'd200);
    send_tick(16'h0008, 16'h0000, 32'd300);
    // partial progress on seq3, then a pattern rewrite must clear it
    send_tick(16'h0002, 16'h0000, 32'd400);
    wait_drained();
    write_reg(CFG_PAT_BASE + 3, 44'h000_0004_6413);
    cfg_quiet();
    send_tick(16'h0000, 16'h0006, 32'd500);
    // two steps passing in one tick complete seq3
    send_tick(16'h0002, 16'h0000, 32'd600);
    send_tick(16'h0000, 16'h0006, 32'd700);
    // elapsed time exactly equal to the window clears progress
    send_tick(16'h0002, 16'h0000, 32'd800);
    send_tick(16'h0000, 16'h0006, 32'd700 + 32'd65535);
    send_tick(16'hFFFF, 16'h0000, 32'hFFFF_FFFF);
    send_tick(16'h0000, 16'hFFFF, 32'h0000_0000);
    send_tick(16'hFFFF, 16'hFFFF, 32'h8000_0000);
  endtask

  // Result receiver: random stalls per transaction, or one long hold on request
  initial begin : result_sink
    int stall;
    fire_ch.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      if (rx_hold > 0) begin
        stall   = rx_hold;
        rx_hold = 0;
      end else begin
        stall = draw_gap();
      end
      if (stall > 0) begin
        fire_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      fire_ch.ready <= 1'b1;
      do @(posedge clk_i); while (!fire_ch.valid);
      @(negedge clk_i);
    end
  end

  // End the run if no transaction moves for too long
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((tick_ch.valid && tick_ch.ready) || (cfg_ch.valid && cfg_ch.ready) ||
          (fire_ch.valid && fire_ch.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
             STALL_LIMIT, pending);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  initial begin : stimulus
    int s;
    tick_ch.valid           <= 1'b0;
    tick_ch.current_levels  <= '0;
    tick_ch.previous_levels <= '0;
    tick_ch.now_ms          <= '0;
    cfg_ch.valid            <= 1'b0;
    cfg_ch.index            <= '0;
    cfg_ch.data             <= '0;
    calm        = 1'b0;
    tick_live   = 1'b0;
    cfg_live    = 1'b0;
    rx_hold     = 0;
    ticks_sent  = 0;
    writes_done = 0;
    clock_ms    = '0;
    foreach (pat_shadow[k]) begin
      pat_shadow[k] = '0;
      cursor[k]     = 0;
    end
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    directed_ticks();

    for (int ph = 0; ph < PHASES; ph++) begin
      configure_phase(ph);
      calm = (ph == 2 || ph == 3);
      // stall the receiver while ticks keep coming, so the block backs up
      if (ph == 3) rx_hold = HOLD_CYCLES;
      for (int i = 0; i < PHASE_TICKS; i++) begin
        // pause mid-phase until drained and rewrite one pattern with its current value
        if (i == PHASE_TICKS / 2) begin
          wait_drained();
          s = $urandom_range(0, NUM_SEQUENCES - 1);
          write_reg(CFG_PAT_BASE + s, CFG_DATA_W'(pat_shadow[s]));
          cfg_quiet();
        end
        random_tick();
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk_i);

    $display("Summary: %0d ticks and %0d register writes over %0d configuration phases,",
             ticks_sent, writes_done, PHASES);
    $display("  %0d fired masks checked, %0d of them with a completed sequence.",
             checked, fired);
    if (pending != 0) $display("%0d expected results never arrived", pending);
    if (mismatches == 0 && pending == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: files.f
+incdir+hdl
hdl/tesd_pkg.sv
hdl/tesd_if.sv
hdl/timed_edge_sequence_detector.sv
bench/tesd_checker.sv
bench/tb_top.sv
